/* rtl/llti_pkg.sv */
// ----------------------------------------------------------------------------
// llti_pkg
// Shared types, constants and IEEE double helpers for the log-log interpolator.
// ----------------------------------------------------------------------------
package llti_pkg;

	localparam int FRAC_BITS = 40;
	localparam int LOG_W     = 52;   // signed Q12.40
	localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
	localparam logic [63:0] TWO_Q62 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] DBL_MAX = 64'h7FEF_FFFF_FFFF_FFFF;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [4:0] {
		ST_RT_TRY,
		ST_RT_WAIT,
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_LG_START,
		ST_LG_NORM,
		ST_LG_SQ,
		ST_LG_WAIT,
		ST_AR_CHK,
		ST_DIV,
		ST_TM,
		ST_TM_WAIT,
		ST_EX_RD,
		ST_EX_CHK,
		ST_EX_WAIT,
		ST_EX_FIN,
		ST_DONE
	} state_t;

	// IEEE less-than on bit patterns; NaN compares false, -0 equals +0
	function automatic logic dbl_less(input logic [63:0] a, input logic [63:0] b);
		logic        nan;
		logic [63:0] aa, bb, ka, kb;
		nan = (a[62:52] == 11'h7FF && a[51:0] != 52'd0) ||
		      (b[62:52] == 11'h7FF && b[51:0] != 52'd0);
		aa = (a[62:0] == 63'd0) ? 64'd0 : a;
		bb = (b[62:0] == 63'd0) ? 64'd0 : b;
		ka = aa[63] ? ~aa : {1'b1, aa[62:0]};
		kb = bb[63] ? ~bb : {1'b1, bb[62:0]};
		return !nan && (ka < kb);
	endfunction

	// positive, finite and nonzero
	function automatic logic pos_fin(input logic [63:0] v);
		return !v[63] && v[62:52] != 11'h7FF && v[62:0] != 63'd0;
	endfunction

endpackage

/* rtl/log_log_table_interpolator.sv */
// ----------------------------------------------------------------------------
// log_log_table_interpolator
// Table-driven log-log linear interpolation of doubles in Q12.40 fixed point.
// ----------------------------------------------------------------------------
//  channel  | signals                        | content
//  ---------+--------------------------------+------------------------------------
//  in beat  | s_tvalid s_tready s_tdata      | tuser: command; tdata: entry_index,
//           | s_tuser                        |   grid_value, density_value, query
//  out beat | m_tvalid m_tready m_tdata      | tdata: result_value; tuser: in_range
//           | m_tuser                        |
//  config   | cfg_we cfg_wdata               | entries_in_use
//
// After reset the block builds its 40 root constants 2^(2^-j) by bit-serial
// square roots on the shared 64x64 multiplier, during which s_tready stays
// low (config writes are taken). A load beat is written to the table RAMs
// while the block stays idle. A query scans the grid (one grid read per cycle
// from the table RAM), then takes five logs, a bit-serial divide and a
// bit-serial exp. The multiplier (four 32x32 partial products per 64x64
// product) sets the log and exp time. One item is worked on at a time; the
// result register lets a new beat in while the last result waits on m_tready.
module log_log_table_interpolator #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	// [9:0] entry_index, [73:10] grid_value, [137:74] density_value,
	// [201:138] query_value, [207:202] zero
	input  logic [207:0]   s_tdata,
	// [0] command
	input  logic           s_tuser,
	output logic           m_tvalid,
	input  logic           m_tready,
	// [63:0] result_value
	output logic [63:0]    m_tdata,
	// [0] in_range
	output logic           m_tuser,
	input  logic           cfg_we,
	input  logic [10:0]    cfg_wdata
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int FB = llti_pkg::FRAC_BITS;
	localparam int LW = llti_pkg::LOG_W;
	localparam int RW = $clog2(llti_pkg::FRAC_BITS);

	// ---------------- input fields
	logic [9:0]  in_idx;
	logic [63:0] in_grid, in_dens, in_query;
	assign in_idx   = s_tdata[9:0];
	assign in_grid  = s_tdata[73:10];
	assign in_dens  = s_tdata[137:74];
	assign in_query = s_tdata[201:138];

	llti_pkg::state_t state_q, state_d;

	logic s_acc;
	assign s_tready = (state_q == llti_pkg::ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// ---------------- config register, clipped to the table depth
	logic [10:0]   cfg_q;
	logic [CW-1:0] n_eff;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 11'd1024;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end
	assign n_eff = (32'(cfg_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(cfg_q);

	// table RAMs, registered read
	logic [63:0] grid_mem [TABLE_DEPTH];
	logic [63:0] dens_mem [TABLE_DEPTH];
	logic [63:0] grid_rd_q, dens_rd_q;
	logic [AW-1:0] rd_addr;
	logic          tbl_we;
	assign tbl_we = s_acc && s_tuser == llti_pkg::CMD_LOAD && 32'(in_idx) < TABLE_DEPTH;

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			grid_mem[AW'(in_idx)] <= in_grid;
			dens_mem[AW'(in_idx)] <= in_dens;
		end
		grid_rd_q <= grid_mem[rd_addr];
		dens_rd_q <= dens_mem[rd_addr];
	end

	// ---------------- root RAM: 2^(2^-j) in Q1.62
	logic [63:0] root_mem [llti_pkg::FRAC_BITS];
	logic [63:0] root_rd_q;
	logic        root_we;
	logic [63:0] root_wd;
	logic [5:0]  step_q;
	always_ff @(posedge clk) begin
		if (root_we) begin
			root_mem[step_q[RW-1:0]] <= root_wd;
		end
		root_rd_q <= root_mem[step_q[RW-1:0]];
	end

	// ---------------- shared multiplier: 64x64 over four 32x32 beats
	logic         mul_start, mul_run_q;
	logic [63:0]  mul_a, mul_b, ma_q, mb_q;
	logic [1:0]   mk_q;
	logic [127:0] acc_q;
	logic [31:0]  mah, mbh;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	assign mah = mk_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign mbh = mk_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pp  = {32'd0, mah} * {32'd0, mbh};
	always_comb begin
		case (mk_q)
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_run_q <= 1'b0;
			mk_q      <= 2'd0;
		end else if (mul_start) begin
			mul_run_q <= 1'b1;
			mk_q      <= 2'd0;
		end else if (mul_run_q) begin
			mk_q <= mk_q + 2'd1;
			if (mk_q == 2'd3) begin
				mul_run_q <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (mul_start) begin
			ma_q  <= mul_a;
			mb_q  <= mul_b;
			acc_q <= '0;
		end else if (mul_run_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	// ---------------- datapath registers
	logic [CW-1:0]        cnt_q, n_q;
	logic [63:0]          q_q, gp_q, gm_q, dp_q, dm_q;
	logic [5:0]           bit_q;        // sqrt trial bit
	logic [63:0]          x_q, y_q;     // sqrt operand and root
	logic [2:0]           lsel_q;
	logic [52:0]          sig_q;
	logic signed [11:0]   e_q;
	logic [63:0]          m_q;
	logic [FB-1:0]        f_q;
	logic signed [LW-1:0] lp_q, lg_q, lq_q, ldp_q, ldm_q;
	logic [54:0]          rem_q, dv_q;
	logic [FB:0]          t_q;
	logic [52:0]          mag_q;
	logic                 neg_q;
	logic signed [53:0]   a_q;
	logic [63:0]          mant_q;
	logic [63:0]          res_q;
	logic                 inr_q;

	// ---------------- combinational helpers
	logic         scan_less, fetch_ok;
	logic [63:0]  rt_c;
	logic [127:0] rt_t;
	logic [63:0]  lv, mm;
	logic signed [LW:0] den, d1, dn;
	logic [54:0]  rem2;
	logic [63:0]  prod_p;
	logic signed [13:0] kexp;
	logic [5:0]   sh;
	logic [63:0]  ex_bits;

	assign scan_less = llti_pkg::dbl_less(grid_rd_q, q_q);
	assign fetch_ok  = llti_pkg::pos_fin(grid_rd_q) && llti_pkg::pos_fin(dens_rd_q) &&
	                   llti_pkg::pos_fin(gp_q) && llti_pkg::pos_fin(dp_q) &&
	                   llti_pkg::pos_fin(q_q);
	assign rt_c = y_q | (64'd1 << bit_q);
	assign rt_t = {2'b00, x_q, 62'd0};
	assign mm   = acc_q[125:62];
	assign den  = (LW+1)'(lp_q) - (LW+1)'(lg_q);
	assign d1   = (LW+1)'(lq_q) - (LW+1)'(lg_q);
	assign dn   = (LW+1)'(ldp_q) - (LW+1)'(ldm_q);
	assign rem2 = {rem_q[53:0], 1'b0};
	assign prod_p = {11'd0, acc_q[92:40]};
	assign kexp = a_q[53:40];
	assign sh   = 6'(-14'sd1012 - kexp);

	always_comb begin
		case (lsel_q)
			3'd0:    lv = gp_q;
			3'd1:    lv = gm_q;
			3'd2:    lv = q_q;
			3'd3:    lv = dp_q;
			default: lv = dm_q;
		endcase
	end

	always_comb begin
		if (kexp > 14'sd1023) begin
			ex_bits = llti_pkg::DBL_MAX;
		end else if (kexp < -14'sd1074) begin
			ex_bits = 64'd1;
		end else if (kexp >= -14'sd1022) begin
			ex_bits = {1'b0, 11'(kexp + 14'sd1023), mant_q[61:10]};
		end else begin
			ex_bits = mant_q >> sh;
		end
	end

	// ---------------- next state and strobes
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		mul_a     = m_q;
		mul_b     = m_q;
		rd_addr   = '0;
		root_we   = 1'b0;
		root_wd   = y_q;
		case (state_q)
			llti_pkg::ST_RT_TRY: begin
				mul_start = 1'b1;
				mul_a     = rt_c;
				mul_b     = rt_c;
				state_d   = llti_pkg::ST_RT_WAIT;
			end
			llti_pkg::ST_RT_WAIT: begin
				if (!mul_run_q) begin
					root_wd = (acc_q <= rt_t) ? rt_c : y_q;
					if (bit_q == 6'd0) begin
						root_we = 1'b1;
						state_d = (step_q == 6'(FB - 1)) ? llti_pkg::ST_IDLE
						                                 : llti_pkg::ST_RT_TRY;
					end else begin
						state_d = llti_pkg::ST_RT_TRY;
					end
				end
			end
			llti_pkg::ST_IDLE: begin
				if (s_acc && s_tuser == llti_pkg::CMD_QUERY) begin
					state_d = (n_eff == '0) ? llti_pkg::ST_DONE : llti_pkg::ST_SCAN;
				end
			end
			llti_pkg::ST_SCAN: begin
				if (scan_less) begin
					rd_addr = AW'(cnt_q + 1'b1);
					if (cnt_q + 1'b1 >= n_q) begin
						state_d = llti_pkg::ST_DONE;
					end
				end else begin
					rd_addr = AW'(cnt_q - 1'b1);
					state_d = (cnt_q == '0) ? llti_pkg::ST_DONE : llti_pkg::ST_FETCH;
				end
			end
			llti_pkg::ST_FETCH: begin
				state_d = fetch_ok ? llti_pkg::ST_LG_START : llti_pkg::ST_DONE;
			end
			llti_pkg::ST_LG_START: state_d = llti_pkg::ST_LG_NORM;
			llti_pkg::ST_LG_NORM: begin
				if (sig_q[52]) begin
					state_d = llti_pkg::ST_LG_SQ;
				end
			end
			llti_pkg::ST_LG_SQ: begin
				mul_start = 1'b1;
				state_d   = llti_pkg::ST_LG_WAIT;
			end
			llti_pkg::ST_LG_WAIT: begin
				if (!mul_run_q) begin
					if (step_q == 6'(FB - 1)) begin
						state_d = (lsel_q == 3'd4) ? llti_pkg::ST_AR_CHK
						                           : llti_pkg::ST_LG_START;
					end else begin
						state_d = llti_pkg::ST_LG_SQ;
					end
				end
			end
			llti_pkg::ST_AR_CHK: begin
				if (den <= 0) begin
					state_d = llti_pkg::ST_DONE;
				end else if (d1 <= 0 || d1 >= den) begin
					state_d = llti_pkg::ST_TM;
				end else begin
					state_d = llti_pkg::ST_DIV;
				end
			end
			llti_pkg::ST_DIV: begin
				if (step_q == 6'(FB - 1)) begin
					state_d = llti_pkg::ST_TM;
				end
			end
			llti_pkg::ST_TM: begin
				mul_start = 1'b1;
				mul_a     = 64'(t_q);
				mul_b     = 64'(mag_q);
				state_d   = llti_pkg::ST_TM_WAIT;
			end
			llti_pkg::ST_TM_WAIT: begin
				if (!mul_run_q) begin
					state_d = llti_pkg::ST_EX_RD;
				end
			end
			llti_pkg::ST_EX_RD: state_d = llti_pkg::ST_EX_CHK;
			llti_pkg::ST_EX_CHK: begin
				if (a_q[6'(FB - 1) - step_q]) begin
					mul_start = 1'b1;
					mul_a     = mant_q;
					mul_b     = root_rd_q;
					state_d   = llti_pkg::ST_EX_WAIT;
				end else begin
					state_d = (step_q == 6'(FB - 1)) ? llti_pkg::ST_EX_FIN
					                                 : llti_pkg::ST_EX_RD;
				end
			end
			llti_pkg::ST_EX_WAIT: begin
				if (!mul_run_q) begin
					state_d = (step_q == 6'(FB - 1)) ? llti_pkg::ST_EX_FIN
					                                 : llti_pkg::ST_EX_RD;
				end
			end
			llti_pkg::ST_EX_FIN: state_d = llti_pkg::ST_DONE;
			llti_pkg::ST_DONE: begin
				if (!m_tvalid || m_tready) begin
					state_d = llti_pkg::ST_IDLE;
				end
			end
			default: state_d = llti_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= llti_pkg::ST_RT_TRY;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- datapath updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			bit_q    <= 6'd62;
			x_q      <= llti_pkg::TWO_Q62;
			y_q      <= '0;
			m_tvalid <= 1'b0;
		end else begin
			// in DONE the result register load below decides m_tvalid
			if (m_tvalid && m_tready && state_q != llti_pkg::ST_DONE) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				llti_pkg::ST_RT_WAIT: begin
					if (!mul_run_q) begin
						if (bit_q == 6'd0) begin
							x_q    <= root_wd;
							y_q    <= '0;
							bit_q  <= 6'd62;
							step_q <= (step_q == 6'(FB - 1)) ? 6'd0 : step_q + 6'd1;
						end else begin
							y_q   <= root_wd;
							bit_q <= bit_q - 6'd1;
						end
					end
				end
				llti_pkg::ST_IDLE: begin
					q_q   <= in_query;
					n_q   <= n_eff;
					cnt_q <= '0;
					res_q <= '0;
					inr_q <= 1'b0;
				end
				llti_pkg::ST_SCAN: begin
					if (scan_less) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						gp_q <= grid_rd_q;
						dp_q <= dens_rd_q;
					end
				end
				llti_pkg::ST_FETCH: begin
					gm_q   <= grid_rd_q;
					dm_q   <= dens_rd_q;
					lsel_q <= 3'd0;
				end
				llti_pkg::ST_LG_START: begin
					if (lv[62:52] == 11'd0) begin
						sig_q <= {1'b0, lv[51:0]};
						e_q   <= -12'sd1022;
					end else begin
						sig_q <= {1'b1, lv[51:0]};
						e_q   <= $signed({1'b0, lv[62:52]}) - 12'sd1023;
					end
				end
				llti_pkg::ST_LG_NORM: begin
					if (sig_q[52]) begin
						m_q    <= {1'b0, sig_q, 10'd0};
						f_q    <= '0;
						step_q <= '0;
					end else begin
						sig_q <= {sig_q[51:0], 1'b0};
						e_q   <= e_q - 12'sd1;
					end
				end
				llti_pkg::ST_LG_WAIT: begin
					if (!mul_run_q) begin
						f_q <= {f_q[FB-2:0], mm[63]};
						m_q <= mm[63] ? {1'b0, mm[63:1]} : mm;
						if (step_q == 6'(FB - 1)) begin
							step_q <= '0;
							lsel_q <= lsel_q + 3'd1;
							case (lsel_q)
								3'd0:    lp_q  <= {e_q, f_q[FB-2:0], mm[63]};
								3'd1:    lg_q  <= {e_q, f_q[FB-2:0], mm[63]};
								3'd2:    lq_q  <= {e_q, f_q[FB-2:0], mm[63]};
								3'd3:    ldp_q <= {e_q, f_q[FB-2:0], mm[63]};
								default: ldm_q <= {e_q, f_q[FB-2:0], mm[63]};
							endcase
						end else begin
							step_q <= step_q + 6'd1;
						end
					end
				end
				llti_pkg::ST_AR_CHK: begin
					rem_q  <= 55'(d1);
					dv_q   <= 55'(den);
					step_q <= '0;
					neg_q  <= dn < 0;
					mag_q  <= (dn < 0) ? 53'(-dn) : 53'(dn);
					if (d1 <= 0) begin
						t_q <= '0;
					end else if (d1 >= den) begin
						t_q <= {1'b1, {FB{1'b0}}};
					end else begin
						t_q <= '0;
					end
				end
				llti_pkg::ST_DIV: begin
					if (rem2 >= dv_q) begin
						rem_q <= rem2 - dv_q;
						t_q   <= {t_q[FB-1:0], 1'b1};
					end else begin
						rem_q <= rem2;
						t_q   <= {t_q[FB-1:0], 1'b0};
					end
					step_q <= (step_q == 6'(FB - 1)) ? 6'd0 : step_q + 6'd1;
				end
				llti_pkg::ST_TM_WAIT: begin
					if (!mul_run_q) begin
						a_q    <= neg_q ? 54'(ldm_q) - 54'(prod_p)
						                : 54'(ldm_q) + 54'(prod_p);
						mant_q <= llti_pkg::ONE_Q62;
						step_q <= '0;
					end
				end
				llti_pkg::ST_EX_CHK: begin
					if (!a_q[6'(FB - 1) - step_q]) begin
						step_q <= (step_q == 6'(FB - 1)) ? 6'd0 : step_q + 6'd1;
					end
				end
				llti_pkg::ST_EX_WAIT: begin
					if (!mul_run_q) begin
						mant_q <= mm;
						step_q <= (step_q == 6'(FB - 1)) ? 6'd0 : step_q + 6'd1;
					end
				end
				llti_pkg::ST_EX_FIN: begin
					res_q <= ex_bits;
					inr_q <= 1'b1;
				end
				llti_pkg::ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= res_q;
						m_tuser  <= inr_q;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- assertions
	a_mul_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_run_q)
		else $error("multiplier restarted while busy");

	a_zero_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == 64'd0))
		else $error("nonzero result without in_range");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == llti_pkg::ST_SCAN) |-> (cnt_q < n_q))
		else $error("scan index beyond entries in use");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tuser == llti_pkg::CMD_QUERY) |=>
		(state_q == llti_pkg::ST_SCAN || state_q == llti_pkg::ST_DONE))
		else $error("query beat not followed by scan or result");

endmodule
